/* src/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and byte decode for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int KIND_W    = 2;
   localparam int VERDICT_W = 3;

   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;  // (
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;  // )
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;  // ]
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;  // {
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;  // }

   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd3;

   localparam logic [VERDICT_W-1:0] VERDICT_OK            = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_CLOSE_NO_OPEN = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_WRONG_KIND    = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_UNCLOSED      = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_OVERFLOW      = 3'd4;

   // Per-cycle command broadcast to every stack cell.
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } cell_ctl_type;

   function automatic logic [KIND_W-1:0] bracket_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      k = KIND_NONE;
      if (c == CHAR_ROUND_OPEN || c == CHAR_ROUND_CLOSE) begin
         k = KIND_ROUND;
      end else if (c == CHAR_CURLY_OPEN || c == CHAR_CURLY_CLOSE) begin
         k = KIND_CURLY;
      end else if (c == CHAR_SQUARE_OPEN || c == CHAR_SQUARE_CLOSE) begin
         k = KIND_SQUARE;
      end
      return k;
   endfunction

   function automatic logic is_opening(input logic [7:0] c);
      return (c == CHAR_ROUND_OPEN) || (c == CHAR_CURLY_OPEN) ||
             (c == CHAR_SQUARE_OPEN);
   endfunction

endpackage

/* src/bbc_cell.sv */
// ----------------------------------------------------------------------------
// bbc_cell
// One entry of the shifting bracket stack; trades contents with its neighbours.
// ----------------------------------------------------------------------------
module bbc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  bbc_pkg::cell_ctl_type      ctl,
   input  logic [bbc_pkg::KIND_W-1:0] above_kind,
   input  logic                       above_occ,
   input  logic [bbc_pkg::KIND_W-1:0] below_kind,
   input  logic                       below_occ,
   output logic [bbc_pkg::KIND_W-1:0] kind,
   output logic                       occ
);

   logic [bbc_pkg::KIND_W-1:0] kind_ff;
   logic [bbc_pkg::KIND_W-1:0] kind_in;
   logic                       occ_ff;
   logic                       occ_in;

   always_comb begin
      kind_in = kind_ff;
      occ_in  = occ_ff;
      if (ctl.push) begin
         kind_in = above_kind;
         occ_in  = above_occ;
      end else if (ctl.pop) begin
         kind_in = below_kind;
         occ_in  = below_occ;
      end
      // drop everything at the end of a string
      if (ctl.clear) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;
   assign occ  = occ_ff;

endmodule

/* src/bracket_balance_checker.sv */
// The verdict for an accepted last byte is registered and appears on rsp_ in the cycle after it.
// Throughput: one byte per cycle while req_stall is low; each byte moves the cell chain at most once.
// req_stall rises only while a verdict waits behind a stalled rsp_ channel.
// Reset (synchronous) empties the stack, clears the sticky error and the
// output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streaming balanced-bracket checker built on a row of shifting stack cells.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_char_in,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bbc_pkg::VERDICT_W-1:0] rsp_verdict
);

   // The stack is a chain of cells with cell 0 as the top. A push shifts
   // every entry one cell deeper, a pop shifts every entry one cell up, so
   // the top entry and the fullness flag sit at fixed places.
   logic [bbc_pkg::KIND_W-1:0] kind_chain [0:STACK_DEPTH];
   logic                       occ_chain  [0:STACK_DEPTH];

   bbc_pkg::cell_ctl_type      ctl;
   logic                       req_accept;
   logic [bbc_pkg::KIND_W-1:0] byte_kind;
   logic                       byte_open;
   logic                       stack_full;
   logic                       nonempty_after;

   logic [bbc_pkg::VERDICT_W-1:0] err_ff;
   logic [bbc_pkg::VERDICT_W-1:0] err_in;
   logic [bbc_pkg::VERDICT_W-1:0] err_new;
   logic [bbc_pkg::VERDICT_W-1:0] verdict;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [bbc_pkg::VERDICT_W-1:0] rsp_verdict_ff;

   // Take a new transaction unless a verdict is held back by the consumer.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign byte_kind  = bbc_pkg::bracket_kind(req_char_in);
   assign byte_open  = bbc_pkg::is_opening(req_char_in);
   assign stack_full = occ_chain[STACK_DEPTH-1];

   // Bottom boundary: nothing lies beneath the deepest cell.
   assign kind_chain[STACK_DEPTH] = bbc_pkg::KIND_NONE;
   assign occ_chain[STACK_DEPTH]  = 1'b0;

   // Decide push / pop / error for the accepted byte. A sticky error makes
   // every later byte of the string a no-op.
   always_comb begin
      ctl.push  = 1'b0;
      ctl.pop   = 1'b0;
      ctl.clear = req_accept & req_is_last;
      err_new   = err_ff;
      if (req_accept && err_ff == bbc_pkg::VERDICT_OK &&
          byte_kind != bbc_pkg::KIND_NONE) begin
         if (byte_open) begin
            // flag overflow, never wrap
            if (stack_full) begin
               err_new = bbc_pkg::VERDICT_OVERFLOW;
            end else begin
               ctl.push = 1'b1;
            end
         end else begin
            if (!occ_chain[0]) begin
               err_new = bbc_pkg::VERDICT_CLOSE_NO_OPEN;
            end else if (kind_chain[0] != byte_kind) begin
               err_new = bbc_pkg::VERDICT_WRONG_KIND;
            end else begin
               ctl.pop = 1'b1;
            end
         end
      end

      // The last byte is processed first, then judged on the state it leaves.
      nonempty_after = ctl.push | (ctl.pop ? occ_chain[1] : occ_chain[0]);
      if (err_new != bbc_pkg::VERDICT_OK) begin
         verdict = err_new;
      end else if (nonempty_after) begin
         verdict = bbc_pkg::VERDICT_UNCLOSED;
      end else begin
         verdict = bbc_pkg::VERDICT_OK;
      end

      err_in = ctl.clear ? bbc_pkg::VERDICT_OK : err_new;
   end

   // Row of stack cells; cell 0 takes the new kind on a push.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         bbc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .above_kind (byte_kind),
            .above_occ  (1'b1),
            .below_kind (kind_chain[i+1]),
            .below_occ  (occ_chain[i+1]),
            .kind       (kind_chain[i]),
            .occ        (occ_chain[i])
         );
      end else begin : g_inner
         bbc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .above_kind (kind_chain[i-1]),
            .above_occ  (occ_chain[i-1]),
            .below_kind (kind_chain[i+1]),
            .below_occ  (occ_chain[i+1]),
            .kind       (kind_chain[i]),
            .occ        (occ_chain[i])
         );
      end
   end

   // Output register: load on the last byte, hold while stalled.
   always_comb begin
      if (ctl.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= bbc_pkg::VERDICT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // Occupied cells must form an unbroken run from the top.
   logic occ_gap;

   always_comb begin
      occ_gap = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         occ_gap = occ_gap | (occ_chain[i+1] & ~occ_chain[i]);
      end
   end

   a_occ_contiguous : assert property (
      @(posedge clock) disable iff (reset) !occ_gap
   ) else $error("stack cells occupied below an empty cell");

   a_clear_after_last : assert property (
      @(posedge clock) disable iff (reset)
      ctl.clear |=> (!occ_chain[0] && err_ff == bbc_pkg::VERDICT_OK)
   ) else $error("state not cleared after last byte");

   a_verdict_follows_last : assert property (
      @(posedge clock) disable iff (reset)
      ctl.clear |=> rsp_valid_ff
   ) else $error("no verdict after last byte");

   a_error_sticky : assert property (
      @(posedge clock) disable iff (reset)
      (err_ff != bbc_pkg::VERDICT_OK && !ctl.clear) |=> err_ff == $past(err_ff)
   ) else $error("sticky error changed within a string");

   a_no_shift_on_error : assert property (
      @(posedge clock) disable iff (reset)
      err_ff != bbc_pkg::VERDICT_OK |-> (!ctl.push && !ctl.pop)
   ) else $error("stack moved after an error");

endmodule
